FILE: rtl/core/pfc_pkg.sv
// Playfair digraph cipher: shared types, constants and letter/position helpers.
// Used by pfc_square, pfc_ctrl and playfair_digraph_cipher. No dependencies.
`default_nettype none

package pfc_pkg;

    localparam int SIDE  = 5;
    localparam int CELLS = SIDE * SIDE;
    localparam int ALPHA = 26;
    localparam int LW    = 5;                 // letter code width
    localparam int PW    = $clog2(CELLS);     // square position width
    localparam int CW    = $clog2(SIDE);      // row / column width

    localparam logic [LW-1:0] CODE_I = LW'(8);
    localparam logic [LW-1:0] CODE_J = LW'(9);
    localparam logic [LW-1:0] CODE_Z = LW'(25);

    localparam logic [1:0] FN_KEY     = 2'd0;
    localparam logic [1:0] FN_FINISH  = 2'd1;
    localparam logic [1:0] FN_ENCRYPT = 2'd2;

    typedef struct packed {
        logic [1:0]    func;
        logic [LW-1:0] letter_a;
        logic [LW-1:0] letter_b;
    } t_in_item;

    typedef struct packed {
        logic [LW-1:0] cipher_a;
        logic [LW-1:0] cipher_b;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_FILL,
        ST_LOOK,
        ST_CALC,
        ST_OUT
    } t_state;

    // Sequencer commands to the key square store
    typedef struct packed {
        logic          place_en;
        logic [LW-1:0] place_letter;
        logic          pos_rd_en;
        logic [LW-1:0] look_a;
        logic [LW-1:0] look_b;
        logic          cell_rd_en;
    } t_sq_ctrl;

    // Saturate to Z, then fold J into I
    function automatic logic [LW-1:0] fold_letter(input logic [LW-1:0] v);
        logic [LW-1:0] c;
        c = (v > CODE_Z) ? CODE_Z : v;
        return (c == CODE_J) ? CODE_I : c;
    endfunction

    function automatic logic [CW-1:0] pos_row(input logic [PW-1:0] p);
        logic [CW-1:0] r;
        r = '0;
        for (int k = 1; k < SIDE; k++) begin
            if (p >= PW'(k * SIDE)) begin
                r = CW'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] pos_col(input logic [PW-1:0] p);
        logic [PW-1:0] base;
        base = PW'(int'(pos_row(p)) * SIDE);
        return CW'(p - base);
    endfunction

    function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] x);
        return (x == CW'(SIDE - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [PW-1:0] cell_index(input logic [CW-1:0] row,
                                                 input logic [CW-1:0] col);
        return PW'(int'(row) * SIDE + int'(col));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pfc_square.sv
// Key square store: cell memory, letter-to-position memory, used bits, fill count.
// Holds the shared placement unit. Depends on pfc_pkg.
`default_nettype none

module pfc_square (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  pfc_pkg::t_sq_ctrl        i_ctrl,
    input  wire  [pfc_pkg::PW-1:0]   i_cell_x,
    input  wire  [pfc_pkg::PW-1:0]   i_cell_y,
    output logic [pfc_pkg::PW-1:0]   o_pos_a,
    output logic [pfc_pkg::PW-1:0]   o_pos_b,
    output logic [pfc_pkg::LW-1:0]   o_cell_x,
    output logic [pfc_pkg::LW-1:0]   o_cell_y
);
    import pfc_pkg::*;

    logic [LW-1:0]    r_cells [CELLS];
    logic [PW-1:0]    r_pos   [ALPHA];
    logic [ALPHA-1:0] r_used;
    logic [PW-1:0]    r_fill;
    logic [PW-1:0]    r_pos_a;
    logic [PW-1:0]    r_pos_b;
    logic             r_hit_a;
    logic             r_hit_b;
    logic [LW-1:0]    r_cell_x;
    logic [LW-1:0]    r_cell_y;
    logic             place_ok;

    // Place only a fresh letter into a square that still has room
    assign place_ok = i_ctrl.place_en && !r_used[i_ctrl.place_letter]
                      && (r_fill < PW'(CELLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_fill <= '0;
        end else if (place_ok) begin
            r_used[i_ctrl.place_letter] <= 1'b1;
            r_fill                      <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (place_ok) begin
            r_cells[r_fill]             <= i_ctrl.place_letter;
            r_pos[i_ctrl.place_letter]  <= r_fill;
        end
        if (i_ctrl.pos_rd_en) begin
            r_pos_a <= r_pos[i_ctrl.look_a];
            r_pos_b <= r_pos[i_ctrl.look_b];
            r_hit_a <= r_used[i_ctrl.look_a];
            r_hit_b <= r_used[i_ctrl.look_b];
        end
        if (i_ctrl.cell_rd_en) begin
            r_cell_x <= r_cells[i_cell_x];
            r_cell_y <= r_cells[i_cell_y];
        end
    end

    // Unplaced letter sits at the first cell
    assign o_pos_a  = r_hit_a ? r_pos_a : '0;
    assign o_pos_b  = r_hit_b ? r_pos_b : '0;
    assign o_cell_x = r_cell_x;
    assign o_cell_y = r_cell_y;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= PW'(CELLS))
        else $error("fill count past square size");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        place_ok |=> (r_fill == $past(r_fill) + 1'b1) && (r_used != $past(r_used)))
        else $error("placement did not advance fill count and used bits");

    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.place_en |=> $stable(r_fill) && $stable(r_used))
        else $error("square changed without placement");

endmodule

`default_nettype wire

FILE: rtl/core/pfc_ctrl.sv
// Sequencer: input capture, key-letter and fill scan, lookup and read steps.
// Drives the key square store through t_sq_ctrl. Depends on pfc_pkg.
`default_nettype none

module pfc_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  pfc_pkg::t_in_item     i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output pfc_pkg::t_sq_ctrl     o_sq
);
    import pfc_pkg::*;

    t_state        r_state;
    t_state        n_state;
    logic [LW-1:0] r_scan;
    logic [LW-1:0] n_scan;
    logic [LW-1:0] r_a;
    logic [LW-1:0] r_b;
    logic          accept;

    assign accept = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_item.func)
                        FN_KEY:     n_state = ST_KEY;
                        FN_FINISH:  n_state = ST_FILL;
                        FN_ENCRYPT: n_state = ST_LOOK;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_KEY:  n_state = ST_IDLE;
            ST_FILL: begin
                if (r_scan == LW'(ALPHA - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOOK: n_state = ST_CALC;
            ST_CALC: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_scan = r_scan;
        if (accept) begin
            n_scan = '0;
        end else if (r_state == ST_FILL) begin
            n_scan = r_scan + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= fold_letter(i_in_item.letter_a);
            r_b <= fold_letter(i_in_item.letter_b);
        end
    end

    always_comb begin
        o_in_stall        = (r_state != ST_IDLE);
        o_out_valid       = (r_state == ST_OUT);
        o_sq.place_en     = (r_state == ST_KEY)
                            || ((r_state == ST_FILL) && (r_scan != CODE_J));
        o_sq.place_letter = (r_state == ST_KEY) ? r_a : r_scan;
        o_sq.pos_rd_en    = (r_state == ST_LOOK);
        o_sq.look_a       = r_a;
        o_sq.look_b       = r_b;
        o_sq.cell_rd_en   = (r_state == ST_CALC);
    end

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_read_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sq.cell_rd_en |=> o_out_valid)
        else $error("cell read not followed by result");

    a_encrypt_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_item.func == FN_ENCRYPT)) |=> o_sq.pos_rd_en)
        else $error("digraph did not start a position lookup");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> (r_scan <= LW'(ALPHA - 1)))
        else $error("fill scan past last letter");

endmodule

`default_nettype wire

FILE: rtl/core/playfair_digraph_cipher.sv
// Playfair digraph cipher top level: sequencer, key square store, cipher coordinates.
// Instantiates pfc_ctrl and pfc_square. Depends on pfc_pkg.
//
// Usage: items arrive on the input channel (i_in_valid / o_in_stall, payload
// i_in_item). func KEY appends a letter to the key square unless it is already
// there or the square is full; func FINISH fills the remaining cells with the
// unused letters in alphabet order, J left out; func ENCRYPT answers with one
// result item on the output channel (o_out_valid / i_out_stall, payload
// o_out_item). Letters above Z saturate to Z, and J is folded into I. The
// unused func code is dropped with no result.
// Timing: one item is worked on at a time and o_in_stall stays high meanwhile.
// A key letter goes straight to the placement unit; a finish makes one scan step
// per letter through the single placement unit. A digraph goes through position
// lookup, cell read, then the held result; the next item is taken the cycle
// after the result leaves.
// Reset (synchronous, active low) clears the used-letter bits, fill count and
// sequencer; the cell memory keeps its contents and is valid only once written.
// While the receiver stalls, the result holds in the cell read register and no
// new item is taken.
`default_nettype none

module playfair_digraph_cipher (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  pfc_pkg::t_in_item     i_in_item,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output pfc_pkg::t_out_item    o_out_item
);
    import pfc_pkg::*;

    t_sq_ctrl      sq_ctrl;
    logic [PW-1:0] pos_a;
    logic [PW-1:0] pos_b;
    logic [PW-1:0] cell_x;
    logic [PW-1:0] cell_y;
    logic [LW-1:0] cipher_x;
    logic [LW-1:0] cipher_y;
    logic [CW-1:0] row_a;
    logic [CW-1:0] col_a;
    logic [CW-1:0] row_b;
    logic [CW-1:0] col_b;

    pfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sq        (sq_ctrl)
    );

    pfc_square u_square (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (sq_ctrl),
        .i_cell_x (cell_x),
        .i_cell_y (cell_y),
        .o_pos_a  (pos_a),
        .o_pos_b  (pos_b),
        .o_cell_x (cipher_x),
        .o_cell_y (cipher_y)
    );

    // Split both positions into row and column
    assign row_a = pos_row(pos_a);
    assign col_a = pos_col(pos_a);
    assign row_b = pos_row(pos_b);
    assign col_b = pos_col(pos_b);

    // Pick the cipher cells: same row (also identical letters) shifts right,
    // same column shifts down, otherwise swap columns
    always_comb begin
        if (row_a == row_b) begin
            cell_x = cell_index(row_a, wrap_inc(col_a));
            cell_y = cell_index(row_b, wrap_inc(col_b));
        end else if (col_a == col_b) begin
            cell_x = cell_index(wrap_inc(row_a), col_a);
            cell_y = cell_index(wrap_inc(row_b), col_b);
        end else begin
            cell_x = cell_index(row_a, col_b);
            cell_y = cell_index(row_b, col_a);
        end
    end

    // Cell read register doubles as the output register
    assign o_out_item.cipher_a = cipher_x;
    assign o_out_item.cipher_b = cipher_y;

endmodule

`default_nettype wire
